// File: hdl/page_lcd_pixel_writer_macros.svh
// Assertion macros for the page LCD pixel writer.
`ifndef PAGE_LCD_PIXEL_WRITER_MACROS_SVH
`define PAGE_LCD_PIXEL_WRITER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PLW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("plw assertion failed");

// Next-cycle implication, checked out of reset.
`define PLW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("plw assertion failed");

`endif

// File: hdl/plw_pkg.sv
// Shared types and constants for the page LCD pixel writer.
`timescale 1ns / 1ps

package plw_pkg;

    localparam int PLW_COLUMNS       = 102;
    localparam int PLW_ROWS          = 64;
    localparam int PLW_ROWS_PER_PAGE = 8;
    // wide enough for column * pages + page at any legal size
    localparam int PLW_IDX_W         = 13;
    localparam int PLW_PADDR_W       = 4;
    localparam int PLW_PDATA_W       = 32;

    localparam logic [7:0] PLW_NIBBLE_MASK      = 8'h0F;
    localparam logic [7:0] PLW_PAGE_BASE_RST    = 8'd176;
    localparam logic [7:0] PLW_COL_LO_BASE_RST  = 8'd0;
    localparam logic [7:0] PLW_COL_HI_BASE_RST  = 8'd16;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_CHECK = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        REG_PAGE_BASE   = 2'd0,
        REG_COL_LO_BASE = 2'd1,
        REG_COL_HI_BASE = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] page_base;
        logic [7:0] col_lo_base;
        logic [7:0] col_hi_base;
    } t_cfg;

endpackage

// File: hdl/plw_cfg_regs.sv
// APB register file holding the three command base bytes.
`timescale 1ns / 1ps

module plw_cfg_regs import plw_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic [PLW_PADDR_W-1:0] i_paddr,
    input  logic [PLW_PDATA_W-1:0] i_pwdata,
    output logic [PLW_PDATA_W-1:0] o_prdata,
    output logic                   o_pready,
    output t_cfg                   o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign o_pready = 1'b1;
    assign w_idx    = t_reg_idx'(i_paddr[3:2]);
    assign w_wr     = i_psel && i_penable && i_pwrite;
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.page_base   <= PLW_PAGE_BASE_RST;
            r_cfg.col_lo_base <= PLW_COL_LO_BASE_RST;
            r_cfg.col_hi_base <= PLW_COL_HI_BASE_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_PAGE_BASE:   r_cfg.page_base   <= i_pwdata[7:0];
                REG_COL_LO_BASE: r_cfg.col_lo_base <= i_pwdata[7:0];
                REG_COL_HI_BASE: r_cfg.col_hi_base <= i_pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_prdata = '0;
        case (w_idx)
            REG_PAGE_BASE:   o_prdata[7:0] = r_cfg.page_base;
            REG_COL_LO_BASE: o_prdata[7:0] = r_cfg.col_lo_base;
            REG_COL_HI_BASE: o_prdata[7:0] = r_cfg.col_hi_base;
            default:         o_prdata = '0;
        endcase
    end

endmodule

// File: hdl/plw_frame_store.sv
// Page-organized frame memory with a clearing sweep after reset.
`timescale 1ns / 1ps

module plw_frame_store import plw_pkg::*; #(
    parameter int DEPTH  = PLW_COLUMNS * ((PLW_ROWS + PLW_ROWS_PER_PAGE - 1) / PLW_ROWS_PER_PAGE),
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data,
    output logic              o_ready
);

    logic [7:0]        r_mem [0:DEPTH-1];
    logic [7:0]        r_rd_data;
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    assign o_rd_data = r_rd_data;
    assign o_ready   = !r_clearing;

    // one entry zeroed per cycle until the whole store is clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// File: hdl/page_lcd_pixel_writer.sv
// Top level of the page LCD pixel writer.
`timescale 1ns / 1ps
`include "page_lcd_pixel_writer_macros.svh"

// An item is taken when start is high and busy is low. A write item sets or
// clears one pixel and streams four bytes (page command, column low command,
// column high command, data byte) back to back, the first through the item
// register and the output register; busy holds off the next item until the
// write reaches its data byte state. A check item gives one result through
// the same registers; the next item may follow in the very next cycle.
// Results are strobed for one cycle each and cannot be held off. Throughput
// is set by the four-byte output stream of a write and by the frame memory
// (separate read and write ports), read when an item is taken and written in
// the cycle after. After reset it clears one byte per cycle, busy high till
// COLUMNS*ceil(ROWS/8) bytes (816 by default) are clear; APB writes go on.
module page_lcd_pixel_writer import plw_pkg::*; #(
    parameter int COLUMNS = PLW_COLUMNS,
    parameter int ROWS    = PLW_ROWS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PLW_PADDR_W-1:0] paddr,
    input  logic [PLW_PDATA_W-1:0] pwdata,
    output logic [PLW_PDATA_W-1:0] prdata,
    output logic                   pready,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_op,
    input  logic [7:0]             i_row,
    input  logic [7:0]             i_column,
    input  logic                   i_pixel_on,
    output logic                   o_strobe,
    output logic [7:0]             o_out_byte,
    output logic                   o_is_data,
    output logic                   o_hit,
    output logic                   o_last
);

    localparam int PAGES  = (ROWS + PLW_ROWS_PER_PAGE - 1) / PLW_ROWS_PER_PAGE;
    localparam int DEPTH  = COLUMNS * PAGES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COL_LO,
        S_COL_HI,
        S_DATA
    } t_state;

    t_cfg              w_cfg;
    logic              w_store_ready;
    logic [7:0]        w_rd_data;

    logic              w_accept;
    logic [7:0]        w_col_c;
    logic [7:0]        w_row_c;
    logic              w_in_range;
    logic [PLW_IDX_W-1:0] w_idx;

    // item register
    logic              r_v1;
    logic              r_op;
    logic              r_on;
    logic              r_in_range;
    logic [7:0]        r_col;
    logic [4:0]        r_page;
    logic [2:0]        r_bit;
    logic [ADDR_W-1:0] r_addr;
    logic [7:0]        r_data;

    logic [7:0]        w_mask;
    logic [7:0]        w_new_byte;
    logic              w_wr_en;

    t_state            r_state, n_state;
    logic              r_strobe, n_strobe;
    logic [7:0]        r_out_byte, n_out_byte;
    logic              r_is_data, n_is_data;
    logic              r_hit, n_hit;
    logic              r_last, n_last;

    plw_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (w_cfg)
    );

    plw_frame_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_idx[ADDR_W-1:0]),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (w_new_byte),
        .o_ready   (w_store_ready)
    );

    assign busy = !w_store_ready || (r_v1 && (r_op == OP_WRITE))
                  || (r_state == S_COL_LO) || (r_state == S_COL_HI);
    assign w_accept = start && !busy;

    // clamp to the panel; a check out of range reads the clamped byte but reports no hit
    assign w_col_c = ({1'b0, i_column} >= 9'(COLUMNS)) ? 8'(COLUMNS - 1) : i_column;
    assign w_row_c = ({1'b0, i_row} >= 9'(ROWS)) ? 8'(ROWS - 1) : i_row;
    assign w_in_range = ({1'b0, i_column} < 9'(COLUMNS)) && ({1'b0, i_row} < 9'(ROWS));
    assign w_idx = PLW_IDX_W'(w_col_c) * PLW_IDX_W'(PAGES) + PLW_IDX_W'(w_row_c[7:3]);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op       <= i_op;
            r_on       <= i_pixel_on;
            r_in_range <= w_in_range;
            r_col      <= w_col_c;
            r_page     <= w_row_c[7:3];
            r_bit      <= w_row_c[2:0];
            r_addr     <= w_idx[ADDR_W-1:0];
        end
        if (w_wr_en) begin
            r_data <= w_new_byte;
        end
    end

    assign w_mask     = 8'b1 << r_bit;
    assign w_new_byte = r_on ? (w_rd_data | w_mask) : (w_rd_data & ~w_mask);
    assign w_wr_en    = r_v1 && (r_op == OP_WRITE);

    always_comb begin
        n_state    = r_state;
        n_strobe   = 1'b0;
        n_out_byte = '0;
        n_is_data  = 1'b0;
        n_hit      = 1'b0;
        n_last     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (r_v1) begin
                    n_strobe = 1'b1;
                    if (r_op == OP_CHECK) begin
                        n_hit  = r_in_range && ((w_rd_data & w_mask) != 8'd0);
                        n_last = 1'b1;
                    end else begin
                        n_out_byte = w_cfg.page_base | {3'b000, r_page};
                        n_state    = S_COL_LO;
                    end
                end
            end
            S_COL_LO: begin
                n_strobe   = 1'b1;
                n_out_byte = w_cfg.col_lo_base | (r_col & PLW_NIBBLE_MASK);
                n_state    = S_COL_HI;
            end
            S_COL_HI: begin
                n_strobe   = 1'b1;
                n_out_byte = w_cfg.col_hi_base | {4'b0000, r_col[7:4]};
                n_state    = S_DATA;
            end
            S_DATA: begin
                n_strobe   = 1'b1;
                n_out_byte = r_data;
                n_is_data  = 1'b1;
                n_last     = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_v1     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_v1       <= w_accept;
            r_strobe   <= n_strobe;
            r_out_byte <= n_out_byte;
            r_is_data  <= n_is_data;
            r_hit      <= n_hit;
            r_last     <= n_last;
        end
    end

    assign o_strobe   = r_strobe;
    assign o_out_byte = r_out_byte;
    assign o_is_data  = r_is_data;
    assign o_hit      = r_hit;
    assign o_last     = r_last;

    `PLW_ASSERT_NEXT(a_write_holds_busy, start && !busy && (i_op == OP_WRITE), busy)
    `PLW_ASSERT_NOW(a_data_after_cmds, o_strobe && o_is_data, $past(o_strobe) && $past(o_strobe, 2) && $past(o_strobe, 3))
    `PLW_ASSERT_NOW(a_no_write_while_clearing, !w_store_ready, !w_wr_en && !w_accept)
    `PLW_ASSERT_NOW(a_hit_only_on_check, o_strobe && o_hit, o_last && !o_is_data && (o_out_byte == 8'd0))

endmodule
